// ----- rtl/twr_rsp_pkg.sv -----
package twr_rsp_pkg;

	localparam int unsigned FIELD_STAMP_W = 40;
	localparam int unsigned GRID_BITS     = 9;

	localparam logic [1:0] REQ_FRAME   = 2'd0;
	localparam logic [1:0] REQ_TICK    = 2'd1;
	localparam logic [1:0] REQ_REFUSED = 2'd2;

	localparam logic [2:0] ACT_NONE     = 3'd0;
	localparam logic [2:0] ACT_RESPONSE = 3'd1;
	localparam logic [2:0] ACT_RESULT   = 3'd2;
	localparam logic [2:0] ACT_TIMEOUT  = 3'd3;
	localparam logic [2:0] ACT_BAD      = 3'd4;
	localparam logic [2:0] ACT_REARM    = 3'd5;
	localparam logic [2:0] ACT_REFUSED  = 3'd6;

	localparam logic [7:0] MAGIC_FIRST  = 8'h55;
	localparam logic [7:0] MAGIC_SECOND = 8'hAA;
	localparam logic [7:0] FRAME_POLL   = 8'h01;
	localparam logic [7:0] FRAME_RESULT = 8'h04;

	localparam logic [9:0]  MIN_HDR_LEN    = 10'd4;
	localparam logic [9:0]  MIN_RESULT_LEN = 10'd8;
	localparam logic [15:0] MS_CNT_MAX     = 16'hFFFF;

	localparam logic [1:0] CFG_TX_ANT_DELAY  = 2'd0;
	localparam logic [1:0] CFG_REPLY_DELAY   = 2'd1;
	localparam logic [1:0] CFG_RESULT_TMO    = 2'd2;
	localparam logic [1:0] CFG_REARM_PERIOD  = 2'd3;

	localparam logic [15:0] RST_TX_ANT_DELAY = 16'd16385;
	localparam logic [31:0] RST_REPLY_DELAY  = 32'd2555920000;
	localparam logic [15:0] RST_RESULT_TMO   = 16'd120;
	localparam logic [15:0] RST_REARM_PERIOD = 16'd1000;

	typedef struct packed {
		logic [15:0] tx_antenna_delay;
		logic [31:0] reply_delay_ticks;
		logic [15:0] result_timeout_ms;
		logic [15:0] rearm_period_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic                     read_ok;
		logic [7:0]               magic_first;
		logic [7:0]               magic_second;
		logic [7:0]               msg_type;
		logic [7:0]               seq_num;
		logic [9:0]               frame_len;
		logic [FIELD_STAMP_W-1:0] rx_time;
		logic signed [31:0]       payload_word;
	} item_t;

	typedef struct packed {
		logic [2:0]               action;
		logic                     rearm_rx;
		logic [7:0]               resp_seq;
		logic [FIELD_STAMP_W-1:0] target_tx_time;
		logic [FIELD_STAMP_W-1:0] reply_delay;
		logic signed [31:0]       distance_mm;
	} result_t;

endpackage

// ----- rtl/twr_rsp_cfg.sv -----
module twr_rsp_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wen,
	input  logic [1:0]         cfg_idx,
	input  logic [31:0]        cfg_wdata,
	output twr_rsp_pkg::cfg_t  cfg
);

	twr_rsp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tx_antenna_delay  <= twr_rsp_pkg::RST_TX_ANT_DELAY;
			cfg_q.reply_delay_ticks <= twr_rsp_pkg::RST_REPLY_DELAY;
			cfg_q.result_timeout_ms <= twr_rsp_pkg::RST_RESULT_TMO;
			cfg_q.rearm_period_ms   <= twr_rsp_pkg::RST_REARM_PERIOD;
		end else if (cfg_wen) begin
			case (cfg_idx)
				twr_rsp_pkg::CFG_TX_ANT_DELAY: cfg_q.tx_antenna_delay  <= cfg_wdata[15:0];
				twr_rsp_pkg::CFG_REPLY_DELAY:  cfg_q.reply_delay_ticks <= cfg_wdata;
				twr_rsp_pkg::CFG_RESULT_TMO:   cfg_q.result_timeout_ms <= cfg_wdata[15:0];
				twr_rsp_pkg::CFG_REARM_PERIOD: cfg_q.rearm_period_ms   <= cfg_wdata[15:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/twr_rsp_core.sv -----
module twr_rsp_core #(
	parameter int unsigned STAMP_BITS = 40
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  twr_rsp_pkg::item_t    item,
	input  twr_rsp_pkg::cfg_t     cfg,
	output twr_rsp_pkg::result_t  res
);

	logic        waiting_q;
	logic [7:0]  held_seq_q;
	logic [15:0] wait_ms_q;
	logic [15:0] rearm_ms_q;

	logic        waiting_d;
	logic [7:0]  held_seq_d;
	logic [15:0] wait_ms_d;
	logic [15:0] rearm_ms_d;

	logic [STAMP_BITS-1:0] poll_time;
	logic [STAMP_BITS-1:0] reply_ticks;
	logic [STAMP_BITS-1:0] target;
	logic [STAMP_BITS-1:0] rdelay;
	logic [twr_rsp_pkg::GRID_BITS-1:0] grid_low;

	logic        good_hdr;
	logic [15:0] wait_inc;
	logic [15:0] rearm_inc;

	assign poll_time   = STAMP_BITS'(64'(item.rx_time));
	assign reply_ticks = STAMP_BITS'(cfg.reply_delay_ticks);
	assign target      = poll_time + reply_ticks;
	assign grid_low    = target[twr_rsp_pkg::GRID_BITS-1:0]
	                   - cfg.tx_antenna_delay[twr_rsp_pkg::GRID_BITS-1:0];
	assign rdelay      = reply_ticks - STAMP_BITS'(grid_low);

	assign good_hdr = item.read_ok && (item.frame_len >= twr_rsp_pkg::MIN_HDR_LEN)
	               && (item.magic_first == twr_rsp_pkg::MAGIC_FIRST)
	               && (item.magic_second == twr_rsp_pkg::MAGIC_SECOND);

	assign wait_inc  = (wait_ms_q == twr_rsp_pkg::MS_CNT_MAX) ? wait_ms_q : wait_ms_q + 16'd1;
	assign rearm_inc = (rearm_ms_q == twr_rsp_pkg::MS_CNT_MAX) ? rearm_ms_q : rearm_ms_q + 16'd1;

	always_comb begin
		waiting_d  = waiting_q;
		held_seq_d = held_seq_q;
		wait_ms_d  = wait_ms_q;
		rearm_ms_d = rearm_ms_q;
		res        = '0;
		case (item.req_type)
			twr_rsp_pkg::REQ_FRAME: begin
				if (!good_hdr) begin
					res.action   = twr_rsp_pkg::ACT_BAD;
					res.rearm_rx = 1'b1;
				end else if (item.msg_type == twr_rsp_pkg::FRAME_POLL) begin
					held_seq_d         = item.seq_num;
					waiting_d          = 1'b1;
					wait_ms_d          = '0;
					res.action         = twr_rsp_pkg::ACT_RESPONSE;
					res.rearm_rx       = 1'b1;
					res.resp_seq       = item.seq_num;
					res.target_tx_time = twr_rsp_pkg::FIELD_STAMP_W'(64'(target));
					res.reply_delay    = twr_rsp_pkg::FIELD_STAMP_W'(64'(rdelay));
				end else if (waiting_q && (item.msg_type == twr_rsp_pkg::FRAME_RESULT)
				             && (item.seq_num == held_seq_q)
				             && (item.frame_len >= twr_rsp_pkg::MIN_RESULT_LEN)) begin
					waiting_d       = 1'b0;
					res.action      = twr_rsp_pkg::ACT_RESULT;
					res.rearm_rx    = 1'b1;
					res.distance_mm = item.payload_word;
				end
			end
			twr_rsp_pkg::REQ_TICK: begin
				rearm_ms_d = rearm_inc;
				if (waiting_q) begin
					wait_ms_d = wait_inc;
					if (wait_inc > cfg.result_timeout_ms) begin
						waiting_d    = 1'b0;
						res.action   = twr_rsp_pkg::ACT_TIMEOUT;
						res.rearm_rx = 1'b1;
					end
				end
				if (!waiting_d && (rearm_inc > cfg.rearm_period_ms)) begin
					rearm_ms_d   = '0;
					res.rearm_rx = 1'b1;
					if (res.action == twr_rsp_pkg::ACT_NONE) begin
						res.action = twr_rsp_pkg::ACT_REARM;
					end
				end
			end
			twr_rsp_pkg::REQ_REFUSED: begin
				waiting_d    = 1'b0;
				res.action   = twr_rsp_pkg::ACT_REFUSED;
				res.rearm_rx = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q  <= 1'b0;
			held_seq_q <= '0;
			wait_ms_q  <= '0;
			rearm_ms_q <= '0;
		end else if (step) begin
			waiting_q  <= waiting_d;
			held_seq_q <= held_seq_d;
			wait_ms_q  <= wait_ms_d;
			rearm_ms_q <= rearm_ms_d;
		end
	end

endmodule

// ----- rtl/twr_responder_sequencer_unit.sv -----
// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid / s_tready  s_tuser event kind, s_tdata frame fields
// m_*       out  m_tvalid / m_tready  m_tuser action, m_tdata response fields
// cfg_*     in   cfg_wen              cfg_idx register index, cfg_wdata value
//
// One transaction per cycle sustained while m_tready is high; accepted input passes both registers to result valid.
// An input register feeds the event logic, whose result lands in the output register.
// arst_n clears valids, exchange state and loads register defaults; no clearing pass.
// A stalled output holds; the input register still takes one transaction behind it.
module twr_responder_sequencer_unit #(
	parameter int unsigned STAMP_BITS = 40
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// read_ok, magic_first, magic_second, msg_type, seq_num, frame_len, rx_time, payload_word
	input  logic [119:0] s_tdata,
	// req_type
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rearm_rx, resp_seq, target_tx_time, reply_delay, distance_mm
	output logic [127:0] m_tdata,
	// action
	output logic [2:0]   m_tuser,
	input  logic         cfg_wen,
	input  logic [1:0]   cfg_idx,
	input  logic [31:0]  cfg_wdata
);

	twr_rsp_pkg::item_t   item_in;
	twr_rsp_pkg::item_t   item_s1;
	twr_rsp_pkg::result_t res_comb;
	twr_rsp_pkg::result_t res_s2;
	twr_rsp_pkg::cfg_t    cfg;

	logic valid_s1;
	logic valid_s2;
	logic adv_s2;
	logic step;

	always_comb begin
		item_in.req_type     = s_tuser;
		item_in.read_ok      = s_tdata[0];
		item_in.magic_first  = s_tdata[8:1];
		item_in.magic_second = s_tdata[16:9];
		item_in.msg_type     = s_tdata[24:17];
		item_in.seq_num      = s_tdata[32:25];
		item_in.frame_len    = s_tdata[42:33];
		item_in.rx_time      = s_tdata[82:43];
		item_in.payload_word = s_tdata[114:83];
	end

	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign step     = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= item_in;
		end
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	twr_rsp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	twr_rsp_core #(
		.STAMP_BITS (STAMP_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.action;
	assign m_tdata  = {7'd0, res_s2.distance_mm, res_s2.reply_delay, res_s2.target_tx_time,
	                   res_s2.resp_seq, res_s2.rearm_rx};

endmodule

// ----- rtl/twr_rsp_chk.sv -----
module twr_rsp_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [127:0] m_tdata,
	input logic [2:0]   m_tuser
);

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled output transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == twr_rsp_pkg::ACT_NONE) |-> (m_tdata == '0))
		else $error("idle action carries nonzero payload");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != twr_rsp_pkg::ACT_NONE) |-> m_tdata[0])
		else $error("action without receiver rearm");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != twr_rsp_pkg::ACT_RESPONSE) |-> (m_tdata[88:1] == '0))
		else $error("response fields set outside a scheduled response");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != twr_rsp_pkg::ACT_RESULT) |-> (m_tdata[120:89] == '0))
		else $error("distance set outside a taken result");

endmodule

bind twr_responder_sequencer_unit twr_rsp_chk u_twr_rsp_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
